// ----- hdl/owrw_pkg.sv -----
// Shared constants, codes and types of the one-wire reset and write unit.
package owrw_pkg;

	localparam int BITS_PER_BYTE = 8;
	localparam int TIMER_WIDTH   = 10;
	localparam int BYTE_W        = 8;
	localparam int CFG_W         = 10;
	localparam int CFG_IDX_W     = 3;
	localparam int OPCODE_W      = 2;
	localparam int PHASE_W       = 4;
	localparam int BIDX_W        = $clog2(BITS_PER_BYTE + 1);

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_RESET = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRES_WAIT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOV  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_LOW      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ONE_RELEASE  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LOW     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_RELEASE = 3'd6;

	// register reset values
	localparam logic [CFG_W-1:0] RST_RESET_LOW    = 10'd485;
	localparam logic [CFG_W-1:0] RST_PRES_WAIT    = 10'd65;
	localparam logic [CFG_W-1:0] RST_RESET_RECOV  = 10'd480;
	localparam logic [CFG_W-1:0] RST_ONE_LOW      = 10'd2;
	localparam logic [CFG_W-1:0] RST_ONE_RELEASE  = 10'd65;
	localparam logic [CFG_W-1:0] RST_ZERO_LOW     = 10'd65;
	localparam logic [CFG_W-1:0] RST_ZERO_RELEASE = 10'd5;

	// sequencer phases
	localparam logic [PHASE_W-1:0] PH_IDLE      = 4'd0;
	localparam logic [PHASE_W-1:0] PH_RST_LOW   = 4'd1;
	localparam logic [PHASE_W-1:0] PH_RST_WAIT  = 4'd2;
	localparam logic [PHASE_W-1:0] PH_RST_RECOV = 4'd3;
	localparam logic [PHASE_W-1:0] PH_WR_LOW    = 4'd4;
	localparam logic [PHASE_W-1:0] PH_WR_REL    = 4'd5;

	typedef struct packed {
		logic [CFG_W-1:0] reset_low_us;
		logic [CFG_W-1:0] presence_wait_us;
		logic [CFG_W-1:0] reset_recovery_us;
		logic [CFG_W-1:0] one_low_us;
		logic [CFG_W-1:0] one_release_us;
		logic [CFG_W-1:0] zero_low_us;
		logic [CFG_W-1:0] zero_release_us;
	} timing_t;

	typedef struct packed {
		logic [PHASE_W-1:0]     phase;
		logic [TIMER_WIDTH-1:0] slot_timer;
		logic [BIDX_W-1:0]      bit_index;
		logic [BYTE_W-1:0]      send_shift;
		logic                   presence_flag;
		logic                   line_drive;
	} bus_state_t;

endpackage

// ----- hdl/owrw_if.sv -----
// Valid/ready channel interfaces for command words and status words.
interface owrw_cmd_if;
	logic                            valid;
	logic                            ready;
	logic [owrw_pkg::OPCODE_W-1:0]   opcode;
	logic [owrw_pkg::BYTE_W-1:0]     tx_byte;
	logic                            line_level;

	modport source (output valid, output opcode, output tx_byte, output line_level,
		input ready);
	modport sink (input valid, input opcode, input tx_byte, input line_level,
		output ready);
endinterface

interface owrw_res_if;
	logic valid;
	logic ready;
	logic drive_low;
	logic busy_res;
	logic presence;
	logic done_res;

	modport source (output valid, output drive_low, output busy_res, output presence,
		output done_res, input ready);
	modport sink (input valid, input drive_low, input busy_res, input presence,
		input done_res, output ready);
endinterface

// ----- hdl/owrw_step.sv -----
// Next-state logic of the bus sequencer for one command or tick word.
module owrw_step (
	input  owrw_pkg::bus_state_t              cur,
	input  owrw_pkg::timing_t                 timing,
	input  logic [owrw_pkg::OPCODE_W-1:0]     opcode,
	input  logic [owrw_pkg::BYTE_W-1:0]       tx_byte,
	input  logic                              line_level,
	output owrw_pkg::bus_state_t              nxt,
	output logic                              done
);

	logic                              is_idle;
	logic [owrw_pkg::BIDX_W-1:0]       bit_next;
	logic [owrw_pkg::BYTE_W-1:0]       shift_next;

	assign is_idle    = (cur.phase == owrw_pkg::PH_IDLE);
	assign bit_next   = cur.bit_index + 1'b1;
	assign shift_next = cur.send_shift >> 1;

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		if (opcode == owrw_pkg::OP_RESET && is_idle) begin
			nxt.line_drive = 1'b1;
			nxt.phase      = owrw_pkg::PH_RST_LOW;
			nxt.slot_timer = owrw_pkg::TIMER_WIDTH'(timing.reset_low_us);
		end else if (opcode == owrw_pkg::OP_WRITE && is_idle) begin
			nxt.send_shift = tx_byte;
			nxt.bit_index  = '0;
			nxt.line_drive = 1'b1;
			nxt.phase      = owrw_pkg::PH_WR_LOW;
			nxt.slot_timer = owrw_pkg::TIMER_WIDTH'(tx_byte[0] ? timing.one_low_us
				: timing.zero_low_us);
		end else if (opcode == owrw_pkg::OP_TICK && !is_idle) begin
			if (cur.slot_timer > owrw_pkg::TIMER_WIDTH'(1)) begin
				nxt.slot_timer = cur.slot_timer - 1'b1;
			end else begin
				case (cur.phase)
					owrw_pkg::PH_RST_LOW: begin
						nxt.line_drive = 1'b0;
						nxt.phase      = owrw_pkg::PH_RST_WAIT;
						nxt.slot_timer = owrw_pkg::TIMER_WIDTH'(timing.presence_wait_us);
					end
					owrw_pkg::PH_RST_WAIT: begin
						nxt.presence_flag = ~line_level;
						nxt.phase         = owrw_pkg::PH_RST_RECOV;
						nxt.slot_timer    = owrw_pkg::TIMER_WIDTH'(timing.reset_recovery_us);
					end
					owrw_pkg::PH_RST_RECOV: begin
						nxt.phase      = owrw_pkg::PH_IDLE;
						nxt.slot_timer = '0;
						done           = 1'b1;
					end
					owrw_pkg::PH_WR_LOW: begin
						nxt.line_drive = 1'b0;
						nxt.phase      = owrw_pkg::PH_WR_REL;
						nxt.slot_timer = owrw_pkg::TIMER_WIDTH'(cur.send_shift[0]
							? timing.one_release_us : timing.zero_release_us);
					end
					owrw_pkg::PH_WR_REL: begin
						nxt.bit_index  = bit_next;
						nxt.send_shift = shift_next;
						if (bit_next >= owrw_pkg::BIDX_W'(owrw_pkg::BITS_PER_BYTE)) begin
							nxt.phase      = owrw_pkg::PH_IDLE;
							nxt.slot_timer = '0;
							done           = 1'b1;
						end else begin
							nxt.line_drive = 1'b1;
							nxt.phase      = owrw_pkg::PH_WR_LOW;
							nxt.slot_timer = owrw_pkg::TIMER_WIDTH'(shift_next[0]
								? timing.one_low_us : timing.zero_low_us);
						end
					end
					default: begin
						nxt.phase      = owrw_pkg::PH_IDLE;
						nxt.line_drive = 1'b0;
						nxt.slot_timer = '0;
					end
				endcase
			end
		end
	end

endmodule

// ----- hdl/one_wire_reset_and_write_unit.sv -----
// Top level: one-wire bus master with reset/presence and LSB-first byte write.
// Latency: the status word for a command or tick word is written into the output
// register by the same clock edge that accepts the word.
// Throughput: one word per cycle; the sequencer state and the output register
// both update in the accepting cycle, so stalls come only from the result side.
// Reset (arst_n low): sequencer idle, bus released, timing registers at defaults.
module one_wire_reset_and_write_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [owrw_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [owrw_pkg::CFG_W-1:0]         cfg_data,
	owrw_cmd_if.sink                           cmd,
	owrw_res_if.source                         res
);

	owrw_pkg::timing_t    timing_q;
	owrw_pkg::bus_state_t state_q;
	owrw_pkg::bus_state_t state_next;
	logic                 step_done;
	logic                 cmd_fire;

	logic res_valid_q;
	logic drive_low_q;
	logic busy_q;
	logic presence_q;
	logic done_q;

	// A new word may enter whenever the output register is empty or draining.
	assign cmd.ready = !res_valid_q || res.ready;
	assign cmd_fire  = cmd.valid && cmd.ready;

	// Timing registers; indexes past the list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.reset_low_us      <= owrw_pkg::RST_RESET_LOW;
			timing_q.presence_wait_us  <= owrw_pkg::RST_PRES_WAIT;
			timing_q.reset_recovery_us <= owrw_pkg::RST_RESET_RECOV;
			timing_q.one_low_us        <= owrw_pkg::RST_ONE_LOW;
			timing_q.one_release_us    <= owrw_pkg::RST_ONE_RELEASE;
			timing_q.zero_low_us       <= owrw_pkg::RST_ZERO_LOW;
			timing_q.zero_release_us   <= owrw_pkg::RST_ZERO_RELEASE;
		end else if (cfg_we) begin
			case (cfg_index)
				owrw_pkg::REG_RESET_LOW:    timing_q.reset_low_us      <= cfg_data;
				owrw_pkg::REG_PRES_WAIT:    timing_q.presence_wait_us  <= cfg_data;
				owrw_pkg::REG_RESET_RECOV:  timing_q.reset_recovery_us <= cfg_data;
				owrw_pkg::REG_ONE_LOW:      timing_q.one_low_us        <= cfg_data;
				owrw_pkg::REG_ONE_RELEASE:  timing_q.one_release_us    <= cfg_data;
				owrw_pkg::REG_ZERO_LOW:     timing_q.zero_low_us       <= cfg_data;
				owrw_pkg::REG_ZERO_RELEASE: timing_q.zero_release_us   <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer next state for the word at the input.
	owrw_step u_step (
		.cur        (state_q),
		.timing     (timing_q),
		.opcode     (cmd.opcode),
		.tx_byte    (cmd.tx_byte),
		.line_level (cmd.line_level),
		.nxt        (state_next),
		.done       (step_done)
	);

	// Sequencer state: all of it is control, so all of it is reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase         <= owrw_pkg::PH_IDLE;
			state_q.slot_timer    <= '0;
			state_q.bit_index     <= '0;
			state_q.send_shift    <= '0;
			state_q.presence_flag <= 1'b0;
			state_q.line_drive    <= 1'b0;
		end else if (cmd_fire) begin
			state_q <= state_next;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd_fire) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Status word payload, taken from the post-update state.
	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			drive_low_q <= state_next.line_drive;
			busy_q      <= (state_next.phase != owrw_pkg::PH_IDLE);
			presence_q  <= state_next.presence_flag;
			done_q      <= step_done;
		end
	end

	assign res.valid     = res_valid_q;
	assign res.drive_low = drive_low_q;
	assign res.busy_res  = busy_q;
	assign res.presence  = presence_q;
	assign res.done_res  = done_q;

`ifndef NO_ASSERTIONS
	// The bus is never held low while the sequencer is idle.
	a_idle_released: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == owrw_pkg::PH_IDLE) |-> !state_q.line_drive)
		else $error("bus driven low while idle");

	// A completion word always reports the sequencer as no longer busy.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && done_q) |-> !busy_q)
		else $error("done reported while still busy");

	// Commands and bad opcodes arriving while busy leave the sequencer untouched.
	a_busy_cmd_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_fire && cmd.opcode != owrw_pkg::OP_TICK
			&& state_q.phase != owrw_pkg::PH_IDLE) |=> $stable(state_q))
		else $error("command while busy changed state");

	// The bit counter never runs past the byte length.
	a_bit_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bit_index <= owrw_pkg::BIDX_W'(owrw_pkg::BITS_PER_BYTE))
		else $error("bit index out of range");
`endif

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the one-wire reset and write unit.
module tb_top;

	// Opcode that the unit ignores, and a register index past the last timing register.
	localparam logic [owrw_pkg::OPCODE_W-1:0]  OP_UNUSED = 2'd3;
	localparam logic [owrw_pkg::CFG_IDX_W-1:0] REG_NONE  = 3'd7;

	localparam int MAX_GAP       = 40;  // longest idle stretch on either side
	localparam int SETTLE_CYCLES = 3;   // quiet cycles before a register write
	localparam int MAX_SHOWN     = 10;  // mismatches printed in full

	// One status word as the unit reports it.
	typedef struct packed {
		logic drive_low;
		logic busy;
		logic presence;
		logic done;
	} status_t;

	// One entry of the stimulus list: a command word or a register write.
	typedef struct packed {
		logic                            is_cfg;
		logic [owrw_pkg::OPCODE_W-1:0]   opcode;
		logic [owrw_pkg::BYTE_W-1:0]     tx_byte;
		logic                            line_level;
		logic [owrw_pkg::CFG_IDX_W-1:0]  reg_idx;
		logic [owrw_pkg::CFG_W-1:0]      reg_val;
	} stim_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [owrw_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [owrw_pkg::CFG_W-1:0]     cfg_data;

	owrw_cmd_if cmd_ch();
	owrw_res_if res_ch();

	one_wire_reset_and_write_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch.sink),
		.res       (res_ch.source)
	);

	stim_t   pending_words[$];   // stimulus not yet handed to the unit
	status_t expected_status[$]; // predicted status words, oldest first

	// Predictor copy of the unit: live timing registers and sequencer state.
	owrw_pkg::timing_t    tm_live;
	owrw_pkg::bus_state_t bus;

	// Timing the stimulus generator plans with (tracks what it has written).
	owrw_pkg::timing_t tm_plan;

	logic took_word;        // a command word was accepted at the last rising edge
	int   quiet;            // rising edges since the last expected status drained
	int   send_gap;
	int   recv_stall;
	int   calm_left[2];     // remaining no-idle stretch: [0] sender, [1] receiver
	int   n_bad;
	int   n_words;
	int   n_cfg;
	int   cycle_cnt;
	int   cycle_limit = 32'h7fff_ffff;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Idle lengths: mostly none or short, a few long, and now and then a
	// stretch with no idling at all.
	// ---------------------------------------------------------------------
	function automatic int pick_gap(int side);
		int r;
		if (calm_left[side] > 0) begin
			calm_left[side]--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3) begin
			calm_left[side] = $urandom_range(20, 200);
			return 0;
		end
		if (r < 50)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, MAX_GAP);
	endfunction

	// ---------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------

	// Pull the bus low for the current bit; a one gets the short low time.
	function automatic void begin_slot();
		bus.line_drive = 1'b1;
		bus.phase      = owrw_pkg::PH_WR_LOW;
		bus.slot_timer = bus.send_shift[0] ? tm_live.one_low_us : tm_live.zero_low_us;
	endfunction

	// Apply one command word to the predicted sequencer, return its status word.
	function automatic status_t advance_bus(logic [owrw_pkg::OPCODE_W-1:0] op,
			logic [owrw_pkg::BYTE_W-1:0] tx, logic lvl);
		status_t s;
		logic    done;
		done = 1'b0;
		if (op == owrw_pkg::OP_RESET && bus.phase == owrw_pkg::PH_IDLE) begin
			bus.line_drive = 1'b1;
			bus.phase      = owrw_pkg::PH_RST_LOW;
			bus.slot_timer = tm_live.reset_low_us;
		end else if (op == owrw_pkg::OP_WRITE && bus.phase == owrw_pkg::PH_IDLE) begin
			bus.send_shift = tx;
			bus.bit_index  = '0;
			begin_slot();
		end else if (op == owrw_pkg::OP_TICK && bus.phase != owrw_pkg::PH_IDLE) begin
			// a timer of 0 or 1 ends the interval on this tick
			if (bus.slot_timer > 1) begin
				bus.slot_timer = bus.slot_timer - 1'b1;
			end else begin
				case (bus.phase)
					owrw_pkg::PH_RST_LOW: begin
						bus.line_drive = 1'b0;
						bus.phase      = owrw_pkg::PH_RST_WAIT;
						bus.slot_timer = tm_live.presence_wait_us;
					end
					owrw_pkg::PH_RST_WAIT: begin
						// a device answers by holding the line low
						bus.presence_flag = (lvl == 1'b0);
						bus.phase         = owrw_pkg::PH_RST_RECOV;
						bus.slot_timer    = tm_live.reset_recovery_us;
					end
					owrw_pkg::PH_RST_RECOV: begin
						bus.phase      = owrw_pkg::PH_IDLE;
						bus.slot_timer = '0;
						done           = 1'b1;
					end
					owrw_pkg::PH_WR_LOW: begin
						bus.line_drive = 1'b0;
						bus.phase      = owrw_pkg::PH_WR_REL;
						bus.slot_timer = bus.send_shift[0] ? tm_live.one_release_us
							: tm_live.zero_release_us;
					end
					owrw_pkg::PH_WR_REL: begin
						bus.bit_index  = bus.bit_index + 1'b1;
						bus.send_shift = bus.send_shift >> 1;
						if (bus.bit_index >= owrw_pkg::BITS_PER_BYTE) begin
							bus.phase      = owrw_pkg::PH_IDLE;
							bus.slot_timer = '0;
							done           = 1'b1;
						end else begin
							begin_slot();
						end
					end
					default: begin
						bus.phase      = owrw_pkg::PH_IDLE;
						bus.line_drive = 1'b0;
						bus.slot_timer = '0;
					end
				endcase
			end
		end
		s.drive_low = bus.line_drive;
		s.busy      = (bus.phase != owrw_pkg::PH_IDLE);
		s.presence  = bus.presence_flag;
		s.done      = done;
		return s;
	endfunction

	// ---------------------------------------------------------------------
	// Rising edge: register writes, status check, and prediction for the
	// word accepted at this edge. The output is registered, so a status word
	// seen here always belongs to an earlier command word.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		status_t want;
		status_t got;
		if (!arst_n) begin
			tm_live = '{owrw_pkg::RST_RESET_LOW, owrw_pkg::RST_PRES_WAIT,
				owrw_pkg::RST_RESET_RECOV, owrw_pkg::RST_ONE_LOW,
				owrw_pkg::RST_ONE_RELEASE, owrw_pkg::RST_ZERO_LOW,
				owrw_pkg::RST_ZERO_RELEASE};
			bus       = '0;
			bus.phase = owrw_pkg::PH_IDLE;
			expected_status.delete();
			took_word <= 1'b0;
			quiet     <= 0;
		end else begin
			// new timings only matter from the next interval load
			if (cfg_we) begin
				case (cfg_index)
					owrw_pkg::REG_RESET_LOW:    tm_live.reset_low_us      = cfg_data;
					owrw_pkg::REG_PRES_WAIT:    tm_live.presence_wait_us  = cfg_data;
					owrw_pkg::REG_RESET_RECOV:  tm_live.reset_recovery_us = cfg_data;
					owrw_pkg::REG_ONE_LOW:      tm_live.one_low_us        = cfg_data;
					owrw_pkg::REG_ONE_RELEASE:  tm_live.one_release_us    = cfg_data;
					owrw_pkg::REG_ZERO_LOW:     tm_live.zero_low_us       = cfg_data;
					owrw_pkg::REG_ZERO_RELEASE: tm_live.zero_release_us   = cfg_data;
					default: ;
				endcase
			end

			if (res_ch.valid && res_ch.ready) begin
				got.drive_low = res_ch.drive_low;
				got.busy      = res_ch.busy_res;
				got.presence  = res_ch.presence;
				got.done      = res_ch.done_res;
				if (expected_status.size() == 0) begin
					n_bad++;
					if (n_bad <= MAX_SHOWN)
						$display("unexpected status word drive=%b busy=%b pres=%b done=%b",
							got.drive_low, got.busy, got.presence, got.done);
				end else begin
					want = expected_status.pop_front();
					if (got !== want) begin
						n_bad++;
						if (n_bad <= MAX_SHOWN)
							$display({"status mismatch: exp drive=%b busy=%b pres=%b done=%b",
								" got drive=%b busy=%b pres=%b done=%b"},
								want.drive_low, want.busy, want.presence, want.done,
								got.drive_low, got.busy, got.presence, got.done);
					end
				end
			end

			if (cmd_ch.valid && cmd_ch.ready) begin
				expected_status.push_back(advance_bus(cmd_ch.opcode, cmd_ch.tx_byte,
					cmd_ch.line_level));
				took_word <= 1'b1;
			end else begin
				took_word <= 1'b0;
			end

			quiet <= (expected_status.size() == 0) ? quiet + 1 : 0;
		end
	end

	// ---------------------------------------------------------------------
	// Driver, falling edge. A word stays on the bus until it is taken.
	// Register writes wait until every status word has come back.
	// ---------------------------------------------------------------------
	always @(negedge clk) begin
		logic  hold;
		logic  we;
		stim_t nxt;
		if (arst_n) begin
			hold = cmd_ch.valid;
			we   = 1'b0;
			if (hold && took_word) begin
				hold     = 1'b0;
				send_gap = pick_gap(0);
			end
			if (!hold) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_words.size() > 0) begin
					nxt = pending_words[0];
					if (!nxt.is_cfg) begin
						void'(pending_words.pop_front());
						hold               = 1'b1;
						cmd_ch.opcode     <= nxt.opcode;
						cmd_ch.tx_byte    <= nxt.tx_byte;
						cmd_ch.line_level <= nxt.line_level;
					end else if (expected_status.size() == 0 && quiet >= SETTLE_CYCLES) begin
						void'(pending_words.pop_front());
						we         = 1'b1;
						cfg_index <= nxt.reg_idx;
						cfg_data  <= nxt.reg_val;
						send_gap   = pick_gap(0);
					end
				end
			end
			cmd_ch.valid <= hold;
			cfg_we       <= we;
		end
	end

	// Status side back-pressure, also at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (recv_stall > 0) begin
				recv_stall--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				recv_stall = pick_gap(1);
			end
		end
	end

	// Hang guard.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > cycle_limit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus builders
	// ---------------------------------------------------------------------

	// Ticks an interval really lasts: a register of zero behaves as one.
	function automatic int span(logic [owrw_pkg::CFG_W-1:0] v);
		return (v == 0) ? 1 : int'(v);
	endfunction

	function automatic owrw_pkg::timing_t flat_timing(logic [owrw_pkg::CFG_W-1:0] v);
		return '{v, v, v, v, v, v, v};
	endfunction

	// Mostly tiny intervals so writes stay short, a few longer ones.
	function automatic logic [owrw_pkg::CFG_W-1:0] rand_us();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return owrw_pkg::CFG_W'($urandom_range(0, 4));
		if (r < 95)
			return owrw_pkg::CFG_W'($urandom_range(5, 20));
		return owrw_pkg::CFG_W'($urandom_range(21, 80));
	endfunction

	task automatic put_word(logic [owrw_pkg::OPCODE_W-1:0] op,
			logic [owrw_pkg::BYTE_W-1:0] tx, logic lvl);
		stim_t s;
		s            = '0;
		s.opcode     = op;
		s.tx_byte    = tx;
		s.line_level = lvl;
		pending_words.push_back(s);
		n_words++;
	endtask

	task automatic put_cfg(logic [owrw_pkg::CFG_IDX_W-1:0] idx,
			logic [owrw_pkg::CFG_W-1:0] val);
		stim_t s;
		s         = '0;
		s.is_cfg  = 1'b1;
		s.reg_idx = idx;
		s.reg_val = val;
		pending_words.push_back(s);
		n_cfg++;
	endtask

	task automatic put_timing(owrw_pkg::timing_t t);
		put_cfg(owrw_pkg::REG_RESET_LOW,    t.reset_low_us);
		put_cfg(owrw_pkg::REG_PRES_WAIT,    t.presence_wait_us);
		put_cfg(owrw_pkg::REG_RESET_RECOV,  t.reset_recovery_us);
		put_cfg(owrw_pkg::REG_ONE_LOW,      t.one_low_us);
		put_cfg(owrw_pkg::REG_ONE_RELEASE,  t.one_release_us);
		put_cfg(owrw_pkg::REG_ZERO_LOW,     t.zero_low_us);
		put_cfg(owrw_pkg::REG_ZERO_RELEASE, t.zero_release_us);
		tm_plan = t;
	endtask

	// lvl_mode: 0 line low, 1 line high, 2 random. Noise words are stray
	// commands, mostly ignored because the sequencer is busy.
	task automatic put_ticks(int n, int lvl_mode, int noise_pct);
		logic [owrw_pkg::OPCODE_W-1:0] op;
		logic                          lvl;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < noise_pct) begin
				case ($urandom_range(0, 2))
					0:       op = owrw_pkg::OP_RESET;
					1:       op = owrw_pkg::OP_WRITE;
					default: op = OP_UNUSED;
				endcase
				put_word(op, owrw_pkg::BYTE_W'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
			end
			lvl = (lvl_mode == 2) ? 1'($urandom_range(0, 1)) : 1'(lvl_mode);
			put_word(owrw_pkg::OP_TICK, owrw_pkg::BYTE_W'($urandom_range(0, 255)), lvl);
		end
	endtask

	// A cut sequence stops short of completion on purpose.
	task automatic put_reset(int lvl_mode, int noise_pct, bit cut);
		int n;
		n = span(tm_plan.reset_low_us) + span(tm_plan.presence_wait_us)
			+ span(tm_plan.reset_recovery_us);
		put_word(owrw_pkg::OP_RESET, owrw_pkg::BYTE_W'($urandom_range(0, 255)),
			1'($urandom_range(0, 1)));
		put_ticks(cut ? $urandom_range(0, n - 1) : n + $urandom_range(0, 3),
			lvl_mode, noise_pct);
	endtask

	task automatic put_write(logic [owrw_pkg::BYTE_W-1:0] tx, int noise_pct, bit cut);
		int n;
		n = 0;
		for (int i = 0; i < owrw_pkg::BITS_PER_BYTE; i++)
			n += tx[i] ? span(tm_plan.one_low_us) + span(tm_plan.one_release_us)
				: span(tm_plan.zero_low_us) + span(tm_plan.zero_release_us);
		put_word(owrw_pkg::OP_WRITE, tx, 1'($urandom_range(0, 1)));
		put_ticks(cut ? $urandom_range(0, n - 1) : n + $urandom_range(0, 3), 2, noise_pct);
	endtask

	// ---------------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------------
	initial begin
		owrw_pkg::timing_t t;
		int                rand_start;
		int                r;
		bit                cut;

		arst_n            = 1'b0;
		cfg_we            = 1'b0;
		cfg_index         = '0;
		cfg_data          = '0;
		cmd_ch.valid      = 1'b0;
		cmd_ch.opcode     = owrw_pkg::OP_TICK;
		cmd_ch.tx_byte    = '0;
		cmd_ch.line_level = 1'b0;
		res_ch.ready      = 1'b0;
		took_word         = 1'b0;
		send_gap          = 0;
		recv_stall        = 0;
		calm_left[0]      = 0;
		calm_left[1]      = 0;
		quiet             = 0;
		n_bad             = 0;
		n_words           = 0;
		n_cfg             = 0;
		cycle_cnt         = 0;
		tm_plan           = '{owrw_pkg::RST_RESET_LOW, owrw_pkg::RST_PRES_WAIT,
			owrw_pkg::RST_RESET_RECOV, owrw_pkg::RST_ONE_LOW,
			owrw_pkg::RST_ONE_RELEASE, owrw_pkg::RST_ZERO_LOW,
			owrw_pkg::RST_ZERO_RELEASE};

		// directed: idle tick, unused opcode while idle
		put_word(owrw_pkg::OP_TICK, 8'h00, 1'b0);
		put_word(OP_UNUSED, 8'hFF, 1'b1);

		// one-microsecond timings; stray index must be dropped
		put_timing(flat_timing(10'd1));
		put_cfg(REG_NONE, 10'h3FF);

		// reset with a device answering, commands while busy ignored
		put_word(owrw_pkg::OP_RESET, 8'h00, 1'b1);
		put_word(owrw_pkg::OP_WRITE, 8'hFF, 1'b1);
		put_word(OP_UNUSED, 8'h00, 1'b0);
		put_ticks(4, 0, 0);
		// reset with no answer: presence holds until the sample, then clears
		put_reset(1, 0, 0);
		put_write(8'hFF, 0, 0);
		put_write(8'h00, 0, 0);

		// all registers zero: every interval acts as one tick
		put_timing(flat_timing(10'd0));
		put_reset(2, 0, 0);
		put_write(8'hA5, 0, 0);

		// long reset pulse with the timer's top bit set, other intervals short
		t              = flat_timing(10'd1);
		t.reset_low_us = 10'h200;
		put_timing(t);
		put_reset(2, 5, 0);

		// random phases: fresh timing, then a handful of operations
		rand_start = n_words;
		while (n_words - rand_start < 400) begin
			t.reset_low_us      = rand_us();
			t.presence_wait_us  = rand_us();
			t.reset_recovery_us = rand_us();
			t.one_low_us        = rand_us();
			t.one_release_us    = rand_us();
			t.zero_low_us       = rand_us();
			t.zero_release_us   = rand_us();
			put_timing(t);
			if ($urandom_range(0, 9) == 0)
				put_cfg(REG_NONE, owrw_pkg::CFG_W'($urandom_range(0, 1023)));
			repeat ($urandom_range(2, 6)) begin
				r   = $urandom_range(0, 99);
				cut = ($urandom_range(0, 9) == 0);
				if (r < 45)
					put_reset(2, 6, cut);
				else if (r < 90)
					put_write(owrw_pkg::BYTE_W'($urandom_range(0, 255)), 6, cut);
				else
					put_ticks($urandom_range(1, 6), 2, 50);
			end
		end

		// worst case per entry: longest sender gap plus longest receiver stall
		cycle_limit = (n_words + n_cfg) * 4 * (2 * MAX_GAP + 4) + 20000;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_words.size() > 0 || cmd_ch.valid || expected_status.size() > 0)
			@(posedge clk);
		// status is one register deep; a few extra edges catch stray words
		repeat (8) @(posedge clk);

		if (n_bad == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/owrw_pkg.sv
hdl/owrw_if.sv
hdl/owrw_step.sv
hdl/one_wire_reset_and_write_unit.sv
test/tb_top.sv
